// File: hw/rtl/rbt_pkg.sv
`timescale 1ns / 1ps

package rbt_pkg;

    // Widest table the chain is built for; the cell command carries this many index bits.
    localparam int IDX_MAX_W = 6;
    localparam int CNT_MAX_W = 7;

    localparam logic [7:0] FLAG_ENABLED = 8'h01;
    localparam logic [7:0] FLAG_EXEC    = 8'h02;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_BADIDX  = 2'd3;

    typedef enum logic [2:0] {
        FN_ADD_EXEC   = 3'd0,
        FN_ADD_RANGE  = 3'd1,
        FN_REM_INDEX  = 3'd2,
        FN_REM_ADDR   = 3'd3,
        FN_ENABLE     = 3'd4,
        FN_DISABLE    = 3'd5,
        FN_LOOKUP     = 3'd6,
        FN_CHECK_EXEC = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        CELL_NOP     = 2'd0,
        CELL_LOAD    = 2'd1,
        CELL_ENABLE  = 2'd2,
        CELL_DISABLE = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MATCH = 2'd1,
        S_PICK  = 2'd2
    } t_state;

    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [7:0]  flags;
    } t_entry;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_MAX_W-1:0]   target;
        t_entry                 data;
    } t_cell_cmd;

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  need;
    } t_key;

endpackage

// File: hw/rtl/rbt_cell.sv
`timescale 1ns / 1ps

module rbt_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  rbt_pkg::t_cell_cmd            i_cmd,
    input  rbt_pkg::t_key                 i_key,
    input  logic [rbt_pkg::CNT_MAX_W-1:0] i_count,
    input  logic                          i_found,
    output logic                          o_found,
    output logic                          o_first,
    input  rbt_pkg::t_entry               i_tail,
    output rbt_pkg::t_entry               o_tail
);
    import rbt_pkg::*;

    t_entry r_entry;
    logic   r_hit;
    logic   in_use;
    logic   is_last;
    logic   hit;

    assign in_use  = CNT_MAX_W'(IDX) < i_count;
    assign is_last = (CNT_MAX_W'(IDX) + CNT_MAX_W'(1)) == i_count;

    // range holds the address and all asked flags are set
    assign hit = in_use
              && (i_key.addr >= r_entry.start_addr)
              && (i_key.addr <= r_entry.end_addr)
              && ((r_entry.flags & i_key.need) == i_key.need);

    always_ff @(posedge i_clk) begin
        r_hit <= hit;
        if (i_cmd.target == IDX_MAX_W'(IDX)) begin
            case (i_cmd.op)
                CELL_LOAD:    r_entry <= i_cmd.data;
                CELL_ENABLE:  r_entry.flags <= r_entry.flags | FLAG_ENABLED;
                CELL_DISABLE: r_entry.flags <= r_entry.flags & ~FLAG_ENABLED;
                default:      r_entry <= r_entry;
            endcase
        end
    end

    // priority: pass on whether a lower cell already hit
    assign o_found = i_found | r_hit;
    assign o_first = r_hit & ~i_found;

    // collect the last live entry along the chain
    always_comb begin
        o_tail.start_addr = i_tail.start_addr | (is_last ? r_entry.start_addr : 32'd0);
        o_tail.end_addr   = i_tail.end_addr   | (is_last ? r_entry.end_addr   : 32'd0);
        o_tail.flags      = i_tail.flags      | (is_last ? r_entry.flags      : 8'd0);
    end

endmodule

// File: hw/rtl/range_breakpoint_table.sv
`timescale 1ns / 1ps

// Channel | Handshake          | Word
// --------+--------------------+-------------------------------------------------
// in      | i_valid / o_ready  | func, address, end_address, flag_bits, entry_index
// out     | o_valid / i_ready  | status, result_index, live_count
//
// Each word passes capture, match in every cell, then priority pick and table
// update, which waits while a stalled result fills the output register. All
// cells compare together; the first hit is taken from the registered hit bits.
// Reset (i_rst_n low at a clock edge) empties the table and the output register.
// A stalled result holds in the output register; a new word is taken once the
// previous result has been loaded there.
module range_breakpoint_table #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_address,
    input  logic [31:0] i_end_address,
    input  logic [7:0]  i_flag_bits,
    input  logic [3:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_result_index,
    output logic [4:0]  o_live_count
);
    import rbt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // state machine
    t_state r_state, n_state;
    logic   accept;
    logic   out_free;
    logic   complete;

    // captured word
    t_func       r_func;
    logic [31:0] r_addr;
    logic [31:0] r_end;
    logic [7:0]  r_flags;
    logic [3:0]  r_eidx;

    // table occupancy
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic       r_out_valid;
    logic [1:0] r_status, n_status;
    logic [3:0] r_ridx;
    logic [IDX_W-1:0] n_ridx;

    // chain wiring
    t_key      key;
    t_cell_cmd cmd;
    logic [ENTRIES:0]   w_found;
    logic [ENTRIES-1:0] w_first;
    t_entry             w_tail [ENTRIES+1];
    t_entry             r_tail;
    logic [IDX_W-1:0]   hit_idx;
    logic               any_hit;
    logic               full;
    logic               idx_ok;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_MATCH;
            S_MATCH: n_state = S_PICK;
            S_PICK:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready  = 1'b0;
        complete = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_MATCH: o_ready = 1'b0;
            S_PICK:  complete = out_free;
            default: o_ready = 1'b0;
        endcase
    end

    // required flags: given flag bits for lookup, exec plus enabled for check, none for remove by address
    always_comb begin
        key.addr = r_addr;
        case (r_func)
            FN_LOOKUP:     key.need = r_flags;
            FN_CHECK_EXEC: key.need = FLAG_EXEC | FLAG_ENABLED;
            default:       key.need = 8'd0;
        endcase
    end

    assign w_found[0] = 1'b0;
    assign w_tail[0]  = '0;

    // one cell per table entry, priority and tail data ripple from cell 0 up
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rbt_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_key   (key),
            .i_count (CNT_MAX_W'(r_count)),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .o_first (w_first[g]),
            .i_tail  (w_tail[g]),
            .o_tail  (w_tail[g+1])
        );
    end

    // encode the one-hot first hit into an index
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_first[i]) hit_idx = hit_idx | IDX_W'(i);
        end
    end

    assign any_hit = w_found[ENTRIES];
    assign full    = r_count == CNT_W'(ENTRIES);
    assign idx_ok  = CNT_MAX_W'(r_eidx) < CNT_MAX_W'(r_count);

    // pick: status, result and the table update for the current word
    always_comb begin
        n_count   = r_count;
        n_status  = ST_OK;
        n_ridx    = '0;
        cmd.op     = CELL_NOP;
        cmd.target = '0;
        cmd.data   = r_tail;
        unique case (r_func)
            FN_ADD_EXEC, FN_ADD_RANGE: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.op              = CELL_LOAD;
                    cmd.target          = IDX_MAX_W'(r_count);
                    cmd.data.start_addr = r_addr;
                    if (r_func == FN_ADD_EXEC) begin
                        cmd.data.end_addr = r_addr;
                        cmd.data.flags    = FLAG_EXEC | FLAG_ENABLED;
                    end else begin
                        cmd.data.end_addr = r_end;
                        cmd.data.flags    = r_flags;
                    end
                    n_ridx  = IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_REM_INDEX, FN_ENABLE, FN_DISABLE: begin
                if (!idx_ok) begin
                    n_status = ST_BADIDX;
                end else begin
                    cmd.target = IDX_MAX_W'(r_eidx);
                    n_ridx     = IDX_W'(r_eidx);
                    if (r_func == FN_REM_INDEX) begin
                        // last entry moves into the hole
                        cmd.op  = CELL_LOAD;
                        n_count = r_count - CNT_W'(1);
                    end else if (r_func == FN_ENABLE) begin
                        cmd.op = CELL_ENABLE;
                    end else begin
                        cmd.op = CELL_DISABLE;
                    end
                end
            end
            FN_REM_ADDR: begin
                if (!any_hit) begin
                    n_status = ST_NOMATCH;
                end else begin
                    cmd.op     = CELL_LOAD;
                    cmd.target = IDX_MAX_W'(hit_idx);
                    n_ridx     = hit_idx;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            FN_LOOKUP, FN_CHECK_EXEC: begin
                if (!any_hit) n_status = ST_NOMATCH;
                else          n_ridx   = hit_idx;
            end
        endcase
        // drop the update unless the result can be loaded this cycle
        if (!complete) cmd.op = CELL_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (complete) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= t_func'(i_func);
            r_addr  <= i_address;
            r_end   <= i_end_address;
            r_flags <= i_flag_bits;
            r_eidx  <= i_entry_index;
        end
        r_tail <= w_tail[ENTRIES];
        if (complete) begin
            r_status <= n_status;
            r_ridx   <= 4'(n_ridx);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_result_index = r_ridx;
    assign o_live_count   = 5'(r_count);

endmodule

// File: hw/rtl/rbt_checker.sv
`timescale 1ns / 1ps

module rbt_checker #(
    parameter int ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_status,
    input  logic [3:0] i_result_index,
    input  logic [4:0] i_live_count
);
    import rbt_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_result_index) && $stable(i_live_count))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // full only when the table holds all entries
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_live_count == 5'(ENTRIES))
        else $error("full status with free entries");

    // failed operations report index zero
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_result_index == 4'd0)
        else $error("index on failed operation");

endmodule

bind range_breakpoint_table rbt_checker #(
    .ENTRIES(ENTRIES)
) u_rbt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_valid),
    .i_out_ready    (i_ready),
    .i_status       (o_status),
    .i_result_index (o_result_index),
    .i_live_count   (o_live_count)
);
